@@ rtl/core/sre_pkg.sv @@
// Package for the shift-reduce expression recognizer: stack sizing, symbol codes,
// beat structs and the character classifier.
// No dependencies.
package sre_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int RED_W       = 6;
    localparam int DEPTH_W     = 7;

    typedef enum logic [2:0] {
        SYM_OTHER = 3'd0,
        SYM_I     = 3'd1,
        SYM_D     = 3'd2,
        SYM_E     = 3'd3,
        SYM_PLUS  = 3'd4,
        SYM_STAR  = 3'd5,
        SYM_LPAR  = 3'd6,
        SYM_RPAR  = 3'd7
    } t_sym;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic               accepted;
        logic               overflow;
        logic [DEPTH_W-1:0] stack_depth;
        logic [RED_W-1:0]   reductions;
    } t_out_beat;

    function automatic t_sym classify(input logic [7:0] c);
        t_sym s;
        case (c)
            8'h69:   s = SYM_I;     // i
            8'h64:   s = SYM_D;     // d
            8'h45:   s = SYM_E;     // E
            8'h2B:   s = SYM_PLUS;  // +
            8'h2A:   s = SYM_STAR;  // *
            8'h28:   s = SYM_LPAR;  // (
            8'h29:   s = SYM_RPAR;  // )
            default: s = SYM_OTHER;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/core/shift_reduce_expression_recognizer.sv @@
// Top level of the shift-reduce expression recognizer: sequencer, symbol stack memory
// and result register. Depends on sre_pkg.
//
// Usage
//   Input channel (i_in_valid / o_in_ready / i_in_data): one beat per character,
//   with a last bit on the final character of a string. Output channel
//   (o_out_valid / i_out_ready / o_out_data): exactly one result beat per input beat.
//   Grammar: E -> E+E | E*E | (E) | id. Each character's symbol is pushed, then the
//   stack top is reduced while a rule matches.
// Timing
//   The symbol stack is one memory with one write and two registered reads. After
//   an accept the sequencer steps through ST_RD1 (reading the top two entries),
//   ST_RD2 (reading the third) and ST_CHK (checking the rules); each reduction loops
//   back through ST_RD1, ST_RD2 and ST_CHK. A new character is accepted only after
//   its predecessor's result is formed and the sequencer is back in idle.
//   o_in_ready is high only while the sequencer is idle.
// Reset and stalls
//   Synchronous active-low reset clears the stack count, the overflow flag and the
//   output valid; stack contents are not cleared, only written entries are read.
//   A finished result waits in the output register. A new beat may be accepted
//   meanwhile, but the sequencer then holds in its check step until the result is
//   taken. On a last beat the count and overflow flag return to zero as it loads.
module shift_reduce_expression_recognizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sre_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sre_pkg::t_out_beat o_out_data
);
    import sre_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD1,   // read n-1 and n-2
        ST_RD2,   // read n-3, hold top two
        ST_CHK    // match rules
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;
    logic               r_last, n_last;
    logic [RED_W-1:0]   r_reds, n_reds;
    t_sym               r_t1, n_t1;
    t_sym               r_t2, n_t2;
    logic               r_out_valid, n_out_valid;
    t_out_beat          r_out, n_out;

    // stack memory
    t_sym               r_stack [STACK_DEPTH];
    t_sym               r_rd_a, r_rd_b;
    logic [ADDR_W-1:0]  rd_addr_a, rd_addr_b, wr_addr;
    logic               wr_en;
    t_sym               wr_data;

    logic [CNT_W-1:0]   cnt_m1, cnt_m2, cnt_m3;
    logic               in_acc, out_free, red_id, red_tri;
    t_sym               t3;

    assign cnt_m1 = r_count - CNT_W'(1);
    assign cnt_m2 = r_count - CNT_W'(2);
    assign cnt_m3 = r_count - CNT_W'(3);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign t3 = r_rd_a;

    // rule match on the top three symbols
    assign red_id  = (r_count >= CNT_W'(2)) && (r_t2 == SYM_I) && (r_t1 == SYM_D);
    assign red_tri = (r_count >= CNT_W'(3)) &&
                     (((t3 == SYM_E) && ((r_t2 == SYM_PLUS) || (r_t2 == SYM_STAR)) &&
                       (r_t1 == SYM_E)) ||
                      ((t3 == SYM_LPAR) && (r_t2 == SYM_E) && (r_t1 == SYM_RPAR)));

    always_comb begin
        rd_addr_a = cnt_m1[ADDR_W-1:0];
        rd_addr_b = cnt_m2[ADDR_W-1:0];
        if (r_state == ST_RD2) begin
            rd_addr_a = cnt_m3[ADDR_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_last      = r_last;
        n_reds      = r_reds;
        n_t1        = r_t1;
        n_t2        = r_t2;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = r_count[ADDR_W-1:0];
        wr_data     = classify(i_in_data.ch);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_last = i_in_data.last;
                    n_reds = '0;
                    if (r_count < CNT_W'(STACK_DEPTH)) begin
                        wr_en   = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_state = ST_RD1;
                end
            end
            ST_RD1: begin
                n_state = ST_RD2;
            end
            ST_RD2: begin
                n_t1    = r_rd_a;
                n_t2    = r_rd_b;
                n_state = ST_CHK;
            end
            ST_CHK: begin
                if (red_id || red_tri) begin
                    wr_en   = 1'b1;
                    wr_data = SYM_E;
                    if (red_id) begin
                        wr_addr = cnt_m2[ADDR_W-1:0];
                        n_count = cnt_m1;
                    end else begin
                        wr_addr = cnt_m3[ADDR_W-1:0];
                        n_count = cnt_m2;
                    end
                    if (r_reds != {RED_W{1'b1}}) begin
                        n_reds = r_reds + RED_W'(1);
                    end
                    n_state = ST_RD1;
                end else if (out_free) begin
                    // with count of one, r_t1 holds entry zero
                    n_out.accepted    = r_last && !r_ovf && (r_count == CNT_W'(1)) &&
                                        (r_t1 == SYM_E);
                    n_out.overflow    = r_ovf;
                    n_out.stack_depth = DEPTH_W'(r_count);
                    n_out.reductions  = r_reds;
                    n_out_valid       = 1'b1;
                    if (r_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
            r_reds      <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
            r_reds      <= n_reds;
        end
        r_t1  <= n_t1;
        r_t2  <= n_t2;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stack[wr_addr] <= wr_data;
        end
        r_rd_a <= r_stack[rd_addr_a];
        r_rd_b <= r_stack[rd_addr_b];
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_accept_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.accepted) |->
            (!o_out_data.overflow && (o_out_data.stack_depth == DEPTH_W'(1))))
        else $error("accepted result with bad stack shape");

    a_reduce_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_CHK) && (red_id || red_tri)) |=> (r_count < $past(r_count)))
        else $error("reduction did not shrink the stack");

endmodule
